[design/dda_lr_pkg.sv]
// Package for the DDA line rasterizer: default parameter values, fixed field
// widths, function codes and the controller/datapath command and status types.
// Depends on nothing.
package dda_lr_pkg;

    localparam int COORD_BITS_DEF     = 16;
    localparam int STEP_FRAC_BITS_DEF = 16;
    localparam int COORD_FRAC         = 4;
    localparam int OUT_BITS           = 13;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;  // latch a new line and set up the divider
        logic div;   // one restoring division iteration
        logic fin;   // round the quotient and form both increments
        logic emit;  // register one pixel and advance the line
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic zero_len;  // the endpoints on the input channel coincide
        logic last;      // the next pixel is the final one of the line
    } t_dp_stat;

endpackage

[design/dda_lr_if.sv]
// Channel interfaces of the DDA line rasterizer: line requests in, pixels out.
// Depends on dda_lr_pkg for default and fixed widths.
interface dda_lr_in_if #(
    parameter int COORD_BITS = dda_lr_pkg::COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, func, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, func, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dda_lr_out_if ();
    logic                                    valid;
    logic                                    ready;
    logic signed [dda_lr_pkg::OUT_BITS-1:0]  pixel_x;
    logic signed [dda_lr_pkg::OUT_BITS-1:0]  pixel_y;
    logic                                    last_pixel;

    modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

[design/dda_lr_ctrl.sv]
// Controller of the DDA line rasterizer: line state, divider sequencing and
// both channel handshakes. Depends on dda_lr_pkg.
module dda_lr_ctrl #(
    parameter int STEP_FRAC_BITS = dda_lr_pkg::STEP_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_func,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  dda_lr_pkg::t_dp_stat i_stat,
    output dda_lr_pkg::t_dp_cmd  o_cmd
);
    import dda_lr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_RUN  = 2'd3;

    localparam int            CW       = $clog2(STEP_FRAC_BITS + 2);
    localparam logic [CW-1:0] DIV_LAST = CW'(STEP_FRAC_BITS + 1);

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          w_take;
    t_dp_cmd       w_cmd;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        w_cmd      = '0;
        o_in_ready = ((r_state == S_IDLE) || (r_state == S_RUN))
                     && (!r_out_valid || i_out_ready);
        w_take     = i_in_valid && o_in_ready;
        case (r_state)
            S_IDLE, S_RUN: begin
                if (w_take) begin
                    if (i_in_func == FUNC_LOAD) begin
                        w_cmd.load = 1'b1;
                        n_cnt      = '0;
                        n_state    = i_stat.zero_len ? S_IDLE : S_DIV;
                    end else if (r_state == S_RUN) begin
                        w_cmd.emit = 1'b1;
                        if (i_stat.last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_DIV: begin
                w_cmd.div = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                w_cmd.fin = 1'b1;
                n_state   = S_RUN;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = (r_out_valid && !i_out_ready) || w_cmd.emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

[design/dda_lr_dp.sv]
// Datapath of the DDA line rasterizer: delta and major length, bit-serial
// step divider, position accumulators, pixel counter and rounded output.
// Depends on dda_lr_pkg.
module dda_lr_dp #(
    parameter int COORD_BITS     = dda_lr_pkg::COORD_BITS_DEF,
    parameter int STEP_FRAC_BITS = dda_lr_pkg::STEP_FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic signed [COORD_BITS-1:0]           i_start_x,
    input  logic signed [COORD_BITS-1:0]           i_start_y,
    input  logic signed [COORD_BITS-1:0]           i_end_x,
    input  logic signed [COORD_BITS-1:0]           i_end_y,
    input  dda_lr_pkg::t_dp_cmd                    i_cmd,
    output dda_lr_pkg::t_dp_stat                   o_stat,
    output logic signed [dda_lr_pkg::OUT_BITS-1:0] o_pixel_x,
    output logic signed [dda_lr_pkg::OUT_BITS-1:0] o_pixel_y,
    output logic                                   o_last_pixel
);
    import dda_lr_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int F  = STEP_FRAC_BITS;
    localparam int PW = CB + F - 1;       // accumulator width, signed
    localparam int TW = CB - COORD_FRAC + 1; // pixel count width
    localparam int IW = F + 2;            // increment width, signed
    localparam int QW = F + 2;            // raw quotient width

    localparam logic [F:0]    UNIT_STEP = (F + 1)'(1) << F;
    localparam logic [CB-1:0] PIX_LIM   = CB'(1) << (CB - COORD_FRAC - 1);
    localparam logic [PW:0]   HALF      = (PW + 1)'(1) << (F - 1);

    // Round a Q.F position to an integer pixel, ties away from zero, clamp.
    function automatic logic [OUT_BITS-1:0] round_px(input logic [PW-1:0] pos);
        logic [PW-1:0]         m;
        logic [PW:0]           s;
        logic [CB-1:0]         r;
        logic [CB-1:0]         v;
        logic [CB+OUT_BITS-1:0] e;
        m = pos[PW-1] ? (~pos + 1'b1) : pos;
        s = {1'b0, m} + HALF;
        r = s[PW:F];
        if (r > PIX_LIM) begin
            r = PIX_LIM;
        end
        v = pos[PW-1] ? (~r + 1'b1) : r;
        e = {{OUT_BITS{v[CB-1]}}, v};
        return e[OUT_BITS-1:0];
    endfunction

    logic [CB:0]   w_dx, w_dy, w_ax, w_ay, w_major, w_minor;
    logic [CB+1:0] w_rem_cur, w_rem_sub;
    logic          w_qbit;
    logic [QW:0]   w_qr;
    logic [F:0]    w_min_mag, w_mag_x, w_mag_y;

    logic [PW-1:0] r_pos_x, r_pos_y;
    logic [IW-1:0] r_inc_x, r_inc_y;
    logic [TW-1:0] r_idx, r_total;
    logic [CB:0]   r_major;
    logic [CB+1:0] r_rem;
    logic [QW-1:0] r_quo;
    logic          r_neg_x, r_neg_y, r_x_major, r_y_major;
    logic [OUT_BITS-1:0] r_px, r_py;
    logic          r_last;

    always_comb begin
        w_dx    = {i_end_x[CB-1], i_end_x} - {i_start_x[CB-1], i_start_x};
        w_dy    = {i_end_y[CB-1], i_end_y} - {i_start_y[CB-1], i_start_y};
        w_ax    = w_dx[CB] ? (~w_dx + 1'b1) : w_dx;
        w_ay    = w_dy[CB] ? (~w_dy + 1'b1) : w_dy;
        w_major = (w_ax > w_ay) ? w_ax : w_ay;
        w_minor = (w_ax > w_ay) ? w_ay : w_ax;

        w_rem_cur = r_rem;
        w_qbit    = (w_rem_cur >= {1'b0, r_major});
        w_rem_sub = w_qbit ? (w_rem_cur - {1'b0, r_major}) : w_rem_cur;

        // Rounded quotient: floor((floor(2x) + 1) / 2).
        w_qr      = {1'b0, r_quo} + 1'b1;
        w_min_mag = w_qr[F+1:1];
        w_mag_x   = r_x_major ? UNIT_STEP : w_min_mag;
        w_mag_y   = r_y_major ? UNIT_STEP : w_min_mag;

        o_stat.zero_len = (i_start_x == i_end_x) && (i_start_y == i_end_y);
        o_stat.last     = ({1'b0, r_idx} + 1'b1) >= {1'b0, r_total};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos_x   <= {{(PW - CB - F + COORD_FRAC){i_start_x[CB-1]}}, i_start_x,
                          {(F - COORD_FRAC){1'b0}}};
            r_pos_y   <= {{(PW - CB - F + COORD_FRAC){i_start_y[CB-1]}}, i_start_y,
                          {(F - COORD_FRAC){1'b0}}};
            r_neg_x   <= w_dx[CB];
            r_neg_y   <= w_dy[CB];
            r_x_major <= (w_ax >= w_ay);
            r_y_major <= (w_ay >= w_ax);
            r_major   <= w_major;
            r_rem     <= {1'b0, w_minor};
            r_quo     <= '0;
            r_idx     <= '0;
            r_total   <= w_major[CB:COORD_FRAC] + 1'b1;
        end
        if (i_cmd.div) begin
            r_rem <= {w_rem_sub[CB:0], 1'b0};
            r_quo <= {r_quo[QW-2:0], w_qbit};
        end
        if (i_cmd.fin) begin
            r_inc_x <= r_neg_x ? (~{1'b0, w_mag_x} + 1'b1) : {1'b0, w_mag_x};
            r_inc_y <= r_neg_y ? (~{1'b0, w_mag_y} + 1'b1) : {1'b0, w_mag_y};
        end
        if (i_cmd.emit) begin
            r_px    <= round_px(r_pos_x);
            r_py    <= round_px(r_pos_y);
            r_last  <= o_stat.last;
            r_pos_x <= r_pos_x + {{(PW - IW){r_inc_x[IW-1]}}, r_inc_x};
            r_pos_y <= r_pos_y + {{(PW - IW){r_inc_y[IW-1]}}, r_inc_y};
            r_idx   <= r_idx + 1'b1;
        end
    end

    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_last_pixel = r_last;

endmodule

[design/dda_line_rasterizer_core.sv]
// Top level of the DDA line rasterizer: controller and datapath joined by
// command and status structs. Depends on dda_lr_pkg, dda_lr_if, dda_lr_ctrl, dda_lr_dp.
//
//   Channel   Direction  Contents                               Transaction means
//   i_line    in         func, start_x, start_y, end_x, end_y   load a line or ask a pixel
//   o_pixel   out        pixel_x, pixel_y, last_pixel           one rasterized pixel
//
// A load transaction of a line with distinct endpoints keeps i_line.ready low while the
// bit-serial restoring divider forms the STEP_FRAC_BITS + 2 bit quotient of the minor-axis
// step, and then while that quotient is rounded and both increments are set. A load with
// coincident endpoints leaves the block idle and does not stall. A step transaction on a
// running line emits one pixel, so pixels stream at one per cycle while the consumer keeps
// o_pixel.ready high. The reset is synchronous and active low; it leaves the block idle
// with no pixel pending. A stalled pixel sits in the output register and one further
// transaction is still taken when the consumer takes that pixel in the same cycle;
// otherwise i_line.ready drops until the pixel leaves.
module dda_line_rasterizer_core #(
    parameter int COORD_BITS     = dda_lr_pkg::COORD_BITS_DEF,
    parameter int STEP_FRAC_BITS = dda_lr_pkg::STEP_FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dda_lr_in_if.sink     i_line,
    dda_lr_out_if.source  o_pixel
);
    import dda_lr_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // The controller owns every handshake and the line state; the datapath never
    // sees valid or ready, only the commands derived from them.
    dda_lr_ctrl #(
        .STEP_FRAC_BITS (STEP_FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_line.valid),
        .i_in_func   (i_line.func),
        .o_in_ready  (i_line.ready),
        .o_out_valid (o_pixel.valid),
        .i_out_ready (o_pixel.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // The datapath accumulates the position by one increment per pixel, which is
    // exactly start + index * step, and rounds it into the output register.
    dda_lr_dp #(
        .COORD_BITS     (COORD_BITS),
        .STEP_FRAC_BITS (STEP_FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_start_x    (i_line.start_x),
        .i_start_y    (i_line.start_y),
        .i_end_x      (i_line.end_x),
        .i_end_y      (i_line.end_y),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_pixel_x    (o_pixel.pixel_x),
        .o_pixel_y    (o_pixel.pixel_y),
        .o_last_pixel (o_pixel.last_pixel)
    );

endmodule
